### rtl/core/lqrsg_pkg.sv
package lqrsg_pkg;

    // Field widths fixed by the data format
    localparam int DATA_W  = 32;
    localparam int MODE_W  = 2;
    localparam int MAXO_W  = 31;
    localparam int FRAC_W  = 16;
    localparam int ADDR_W  = 4;

    // Stall guard defaults and thresholds (fractions of 65536)
    localparam int STALL_LIMIT_DEF = 500;
    localparam logic [15:0] SAT_NUM   = 16'd62259;   // 0.95 of the output limit
    localparam logic [11:0] STALL_NUM = 12'd3277;    // 0.05 of the reference
    localparam logic [31:0] REF_MIN   = 32'd32768;   // 0.5 in Q16.16

    // Feedback modes
    localparam logic [MODE_W-1:0] MODE_VEL     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_POS_VEL = 2'd2;

    // Register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_STATE_COUNT = 2'd0,
        REG_GAIN_K0     = 2'd1,
        REG_GAIN_K1     = 2'd2,
        REG_MAX_OUTPUT  = 2'd3
    } t_reg_idx;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic signed [DATA_W-1:0] k0;
        logic signed [DATA_W-1:0] k1;
        logic [MAXO_W-1:0]        max_out;
    } t_cfg;

    // Per-word status handed to the stall guard
    typedef struct packed {
        logic ok;        // mode is valid
        logic idle;      // drive not near limit, or reference small
        logic stalled;   // measure barely follows reference
    } t_flags;

    // Magnitude of a signed word; -2^31 maps to 2^31
    function automatic logic [DATA_W-1:0] abs32(input logic signed [DATA_W-1:0] v);
        logic [DATA_W-1:0] r;
        r = v[DATA_W-1] ? (~v + 1'b1) : v;
        return r;
    endfunction

endpackage

### rtl/core/lqrsg_in_if.sv
interface lqrsg_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [lqrsg_pkg::DATA_W-1:0] position;
    logic signed [lqrsg_pkg::DATA_W-1:0] velocity;
    logic signed [lqrsg_pkg::DATA_W-1:0] reference;

    modport source (output valid, output position, output velocity, output reference,
                    input ready);
    modport sink   (input valid, input position, input velocity, input reference,
                    output ready);
endinterface

### rtl/core/lqrsg_out_if.sv
interface lqrsg_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [lqrsg_pkg::DATA_W-1:0] drive;
    logic                                 blocked;

    modport source (output valid, output drive, output blocked, input ready);
    modport sink   (input valid, input drive, input blocked, output ready);
endinterface

### rtl/core/lqr_state_feedback_stall_guard_top.sv
// LQR state-feedback drive with stall guard. Each word on i_in (position,
// velocity, reference, signed Q16.16) yields one word on o_out (drive, blocked).
// One word is taken per cycle unless o_out.ready stalls the pipeline: input
// register, two 32x33 multiplies, product sum with floor/saturation and
// threshold tests, then the stall counter and output register. Registers are
// written over the APB port (byte address 4*index: state_count, gain_k0,
// gain_k1, max_output); the user must write them only while no word is in
// flight; the block does not enforce it. The stall counter saturates at
// STALL_LIMIT; there the drive reads zero, and blocked is set in a valid mode.
module lqr_state_feedback_stall_guard_top #(
    parameter int STALL_LIMIT = lqrsg_pkg::STALL_LIMIT_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    lqrsg_in_if.sink                             i_in,
    lqrsg_out_if.source                          o_out,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [lqrsg_pkg::ADDR_W-1:0]         paddr,
    input  logic [lqrsg_pkg::DATA_W-1:0]         pwdata,
    output logic [lqrsg_pkg::DATA_W-1:0]         prdata,
    output logic                                 pready
);

    localparam int CW = $clog2(STALL_LIMIT + 1);
    localparam logic [CW-1:0] LIMIT = CW'(STALL_LIMIT);

    // Configuration registers
    lqrsg_pkg::t_cfg      r_cfg;
    lqrsg_pkg::t_reg_idx  w_idx;
    logic                 w_wr;

    // Datapath result
    logic                                 c_vld;
    logic signed [lqrsg_pkg::DATA_W-1:0] c_drive;
    lqrsg_pkg::t_flags                    c_flags;

    // Stall guard and output register
    logic                                 en_o;
    logic                                 r_o_vld;
    logic signed [lqrsg_pkg::DATA_W-1:0] r_o_drive;
    logic                                 r_o_blocked;
    logic [CW-1:0]                        r_cnt, n_cnt;
    logic                                 n_blocked;

    assign pready = 1'b1;
    assign w_idx  = lqrsg_pkg::t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode    <= lqrsg_pkg::MODE_VEL;
            r_cfg.k0      <= '0;
            r_cfg.k1      <= '0;
            r_cfg.max_out <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                lqrsg_pkg::REG_STATE_COUNT: r_cfg.mode    <= pwdata[lqrsg_pkg::MODE_W-1:0];
                lqrsg_pkg::REG_GAIN_K0:     r_cfg.k0      <= pwdata;
                lqrsg_pkg::REG_GAIN_K1:     r_cfg.k1      <= pwdata;
                lqrsg_pkg::REG_MAX_OUTPUT:  r_cfg.max_out <= pwdata[lqrsg_pkg::MAXO_W-1:0];
                default:                    r_cfg.mode    <= r_cfg.mode;
            endcase
        end
    end

    // Register reads
    always_comb begin
        unique case (w_idx)
            lqrsg_pkg::REG_STATE_COUNT: prdata = lqrsg_pkg::DATA_W'(r_cfg.mode);
            lqrsg_pkg::REG_GAIN_K0:     prdata = r_cfg.k0;
            lqrsg_pkg::REG_GAIN_K1:     prdata = r_cfg.k1;
            lqrsg_pkg::REG_MAX_OUTPUT:  prdata = lqrsg_pkg::DATA_W'(r_cfg.max_out);
            default:                    prdata = '0;
        endcase
    end

    lqrsg_calc u_calc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_in    (i_in),
        .i_adv   (en_o),
        .o_vld   (c_vld),
        .o_drive (c_drive),
        .o_flags (c_flags)
    );

    assign en_o = !r_o_vld || o_out.ready;

    // Stall counter update for the word leaving the datapath
    always_comb begin
        n_cnt     = r_cnt;
        n_blocked = 1'b0;
        if (c_flags.ok) begin
            priority if (c_flags.idle) begin
                n_cnt = '0;
            end else if (c_flags.stalled) begin
                n_cnt = (r_cnt < LIMIT) ? r_cnt + 1'b1 : r_cnt;
            end else begin
                n_cnt = '0;
            end
            n_blocked = !c_flags.idle && (n_cnt >= LIMIT);
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld     <= 1'b0;
            r_cnt       <= '0;
            r_o_blocked <= 1'b0;
        end else if (en_o) begin
            r_o_vld <= c_vld;
            if (c_vld) begin
                r_cnt       <= n_cnt;
                r_o_blocked <= n_blocked;
            end
        end
        if (en_o && c_vld) begin
            r_o_drive <= (c_flags.ok && !n_blocked) ? c_drive : '0;
        end
    end

    assign o_out.valid   = r_o_vld;
    assign o_out.drive   = r_o_drive;
    assign o_out.blocked = r_o_blocked;

    // Counter never passes the limit
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= LIMIT)
        else $error("stall counter above limit");

    // A blocked word always carries zero drive
    a_blocked_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && r_o_blocked) |-> (r_o_drive == '0))
        else $error("blocked word with nonzero drive");

    // Blocked only while the counter sits at the limit
    a_blocked_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_blocked |-> (r_cnt == LIMIT))
        else $error("blocked without a full stall count");

    // Counter moves only when a word enters the output register
    a_cnt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(en_o && c_vld) |=> $stable(r_cnt))
        else $error("stall counter changed without a word");

endmodule

### rtl/core/lqrsg_calc.sv
module lqrsg_calc (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  lqrsg_pkg::t_cfg                      i_cfg,
    lqrsg_in_if.sink                             i_in,
    input  logic                                 i_adv,
    output logic                                 o_vld,
    output logic signed [lqrsg_pkg::DATA_W-1:0]  o_drive,
    output lqrsg_pkg::t_flags                    o_flags
);

    localparam int DW = lqrsg_pkg::DATA_W;
    localparam int EW = DW + 1;          // error / negated velocity
    localparam int PW = DW + EW;         // one product
    localparam int SW = PW + 1;          // sum of products
    localparam int HW = SW - lqrsg_pkg::FRAC_W;

    // Stage enables: a stage loads when empty or when it drains
    logic en_a, en_b, en_c;

    // Stage A: input word
    logic                 r_a_vld;
    logic signed [DW-1:0] r_a_pos, r_a_vel, r_a_ref;

    // Stage B: products and magnitudes
    logic                 r_b_vld;
    logic signed [PW-1:0] r_b_p0, r_b_p1;
    logic [DW-1:0]        r_b_mabs, r_b_rabs;
    logic                 r_b_ok;

    // Stage C: saturated drive and guard flags
    logic                 r_c_vld;
    logic signed [DW-1:0] r_c_drive;
    lqrsg_pkg::t_flags    r_c_flags;

    logic signed [EW-1:0] n_e0, n_t;
    logic signed [DW-1:0] n_meas;
    logic signed [SW-1:0] n_sum;
    logic signed [HW-1:0] n_sh;
    logic signed [DW-1:0] n_drive;
    logic [DW-1:0]        n_dabs;
    logic [47:0]          n_sat_thr;
    logic [43:0]          n_stall_thr;
    logic                 n_near_sat;

    assign en_c = !r_c_vld || i_adv;
    assign en_b = !r_b_vld || en_c;
    assign en_a = !r_a_vld || en_b;
    assign i_in.ready = en_a;

    // Stage A load
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (en_a) begin
            r_a_vld <= i_in.valid;
        end
        if (en_a && i_in.valid) begin
            r_a_pos <= i_in.position;
            r_a_vel <= i_in.velocity;
            r_a_ref <= i_in.reference;
        end
    end

    // Tracking error and measure by mode
    always_comb begin
        if (i_cfg.mode == lqrsg_pkg::MODE_VEL) begin
            n_meas = r_a_vel;
        end else begin
            n_meas = r_a_pos;
        end
        n_e0 = EW'(r_a_ref) - EW'(n_meas);
        n_t  = -EW'(r_a_vel);
    end

    // Stage B: the two multiplies
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (en_b) begin
            r_b_vld <= r_a_vld;
        end
        if (en_b && r_a_vld) begin
            r_b_p0   <= PW'(i_cfg.k0) * PW'(n_e0);
            r_b_p1   <= (i_cfg.mode == lqrsg_pkg::MODE_POS_VEL)
                        ? PW'(i_cfg.k1) * PW'(n_t) : '0;
            r_b_mabs <= lqrsg_pkg::abs32(n_meas);
            r_b_rabs <= lqrsg_pkg::abs32(r_a_ref);
            r_b_ok   <= (i_cfg.mode == lqrsg_pkg::MODE_VEL)
                        || (i_cfg.mode == lqrsg_pkg::MODE_POS_VEL);
        end
    end

    // Sum, floor to Q16.16, saturate, threshold tests
    always_comb begin
        n_sum = SW'(r_b_p0) + SW'(r_b_p1);
        n_sh  = n_sum[SW-1:lqrsg_pkg::FRAC_W];
        if (n_sh[HW-1:DW-1] == '0 || n_sh[HW-1:DW-1] == '1) begin
            n_drive = n_sh[DW-1:0];
        end else if (n_sh[HW-1]) begin
            n_drive = {1'b1, {(DW-1){1'b0}}};
        end else begin
            n_drive = {1'b0, {(DW-1){1'b1}}};
        end
        n_dabs      = lqrsg_pkg::abs32(n_drive);
        n_sat_thr   = 48'(i_cfg.max_out) * 48'(lqrsg_pkg::SAT_NUM);
        n_stall_thr = 44'(r_b_rabs) * 44'(lqrsg_pkg::STALL_NUM);
        n_near_sat  = {n_dabs, 16'b0} >= n_sat_thr;
    end

    // Stage C load
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (en_c) begin
            r_c_vld <= r_b_vld;
        end
        if (en_c && r_b_vld) begin
            r_c_drive         <= n_drive;
            r_c_flags.ok      <= r_b_ok;
            r_c_flags.idle    <= !n_near_sat || (r_b_rabs < lqrsg_pkg::REF_MIN);
            r_c_flags.stalled <= {r_b_mabs, 16'b0} < 48'(n_stall_thr);
        end
    end

    assign o_vld   = r_c_vld;
    assign o_drive = r_c_drive;
    assign o_flags = r_c_flags;

endmodule

### test/lqr_state_feedback_stall_guard_top_tb.sv
module lqr_state_feedback_stall_guard_top_tb;
    import lqrsg_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 11;
    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 12;
    localparam int STALL_MAX    = 500;
    localparam int MAX_PRINTS   = 100;

    // Guard thresholds, as fractions of 65536
    localparam int SAT_FRAC  = 62259;
    localparam int MOVE_FRAC = 3277;
    localparam int REF_FLOOR = 32768;

    // Mode codes the block treats as invalid
    localparam logic [MODE_W-1:0] MODE_OFF   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    localparam logic signed [95:0] DRIVE_HI = 96'sd2147483647;
    localparam logic signed [95:0] DRIVE_LO = -96'sd2147483648;

    // Tracks configuration and stall count, predicts each drive word
    class drive_tracker;
        typedef struct {
            logic signed [DATA_W-1:0] drive;
            logic                     blocked;
        } drive_word_t;

        logic [MODE_W-1:0]        mode;
        logic signed [DATA_W-1:0] k0;
        logic signed [DATA_W-1:0] k1;
        logic [MAXO_W-1:0]        max_out;
        int unsigned              stall_cnt;
        drive_word_t              drive_due[$];
        int unsigned              errors;

        function new();
            mode      = MODE_VEL;
            k0        = '0;
            k1        = '0;
            max_out   = '0;
            stall_cnt = 0;
            errors    = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [DATA_W-1:0] val);
            case (idx)
                REG_STATE_COUNT: mode    = val[MODE_W-1:0];
                REG_GAIN_K0:     k0      = val;
                REG_GAIN_K1:     k1      = val;
                REG_MAX_OUTPUT:  max_out = val[MAXO_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [DATA_W-1:0] reg_value(t_reg_idx idx);
            logic [DATA_W-1:0] v;
            case (idx)
                REG_STATE_COUNT: v = DATA_W'(mode);
                REG_GAIN_K0:     v = k0;
                REG_GAIN_K1:     v = k1;
                REG_MAX_OUTPUT:  v = DATA_W'(max_out);
                default:         v = '0;
            endcase
            return v;
        endfunction

        function int pending();
            return drive_due.size();
        endfunction

        task flag_mismatch(string what);
            if (errors < MAX_PRINTS)
                $display("%0t mismatch: %s", $realtime, what);
            errors++;
        endtask

        // Exact product sum, floored to Q16.16, saturated, then the stall guard
        function void add_sample(logic signed [DATA_W-1:0] pos, logic signed [DATA_W-1:0] vel,
                                 logic signed [DATA_W-1:0] refv);
            logic signed [95:0]       xp, xv, xr, g0, g1, acc, q;
            logic signed [63:0]       d64, r64, m64;
            logic [63:0]              dabs, rabs, mabs;
            logic signed [DATA_W-1:0] d, meas;
            drive_word_t              w;
            w.drive   = '0;
            w.blocked = 1'b0;
            if (mode != MODE_VEL && mode != MODE_POS_VEL) begin
                // invalid mode: zero word, count untouched
                drive_due.push_back(w);
                return;
            end
            xp = pos;
            xv = vel;
            xr = refv;
            g0 = k0;
            g1 = k1;
            if (mode == MODE_VEL) begin
                meas = vel;
                acc  = g0 * (xr - xv);
            end else begin
                meas = pos;
                acc  = g0 * (xr - xp) - g1 * xv;
            end
            q = acc >>> FRAC_W;
            if (q > DRIVE_HI)
                d = 32'sh7FFF_FFFF;
            else if (q < DRIVE_LO)
                d = 32'sh8000_0000;
            else
                d = q[DATA_W-1:0];

            d64  = d;
            r64  = refv;
            m64  = meas;
            dabs = (d64 < 0) ? -d64 : d64;
            rabs = (r64 < 0) ? -r64 : r64;
            mabs = (m64 < 0) ? -m64 : m64;

            if (dabs * 65536 < 64'(max_out) * SAT_FRAC || rabs < REF_FLOOR) begin
                stall_cnt = 0;
            end else begin
                if (mabs * 65536 < rabs * MOVE_FRAC) begin
                    if (stall_cnt < STALL_MAX)
                        stall_cnt++;
                end else begin
                    stall_cnt = 0;
                end
                w.blocked = (stall_cnt >= STALL_MAX);
                if (w.blocked)
                    d = '0;
            end
            w.drive = d;
            drive_due.push_back(w);
        endfunction

        task check_result(logic signed [DATA_W-1:0] drive, logic blocked);
            drive_word_t w;
            if (drive_due.size() == 0) begin
                flag_mismatch($sformatf("drive word %0d blocked %0b with none due", drive, blocked));
                return;
            end
            w = drive_due.pop_front();
            if (drive !== w.drive)
                flag_mismatch($sformatf("drive %0d, predicted %0d", drive, w.drive));
            if (blocked !== w.blocked)
                flag_mismatch($sformatf("blocked %0b, predicted %0b", blocked, w.blocked));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;

    lqrsg_in_if  sample_if ();
    lqrsg_out_if drive_if ();

    drive_tracker sb;
    bit           quiet_tail;
    int unsigned  idle_pct;

    lqr_state_feedback_stall_guard_top #(
        .STALL_LIMIT(STALL_MAX)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (sample_if),
        .o_out   (drive_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Sink side: ready drops in random bursts
    initial begin
        int hold;
        hold = 0;
        drive_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold == 0 && !quiet_tail && $urandom_range(0, 99) < idle_pct)
                hold = $urandom_range(1, 13);
            if (hold > 0) begin
                drive_if.ready <= 1'b0;
                hold--;
            end else begin
                drive_if.ready <= 1'b1;
            end
        end
    end

    // Every accepted drive word goes to the checker
    always @(posedge i_clk) begin
        if (i_rst_n && drive_if.valid && drive_if.ready)
            sb.check_result(drive_if.drive, drive_if.blocked);
    end

    // One APB transfer: setup, then access until pready
    task automatic apb_cycle(input bit wr, input t_reg_idx idx, input logic [DATA_W-1:0] wdata,
                             output logic [DATA_W-1:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_reg(input t_reg_idx idx);
        logic [DATA_W-1:0] rd;
        apb_cycle(1'b0, idx, '0, rd);
        if (rd !== sb.reg_value(idx))
            sb.flag_mismatch($sformatf("register %s reads %h, holds %h",
                                       idx.name(), rd, sb.reg_value(idx)));
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [DATA_W-1:0] val);
        logic [DATA_W-1:0] rd;
        apb_cycle(1'b1, idx, val, rd);
        sb.set_reg(idx, val);
        check_reg(idx);
    endtask

    // Offer one word, with an optional gap in front, and wait for it to be taken
    task automatic send_sample(input logic [DATA_W-1:0] pos, input logic [DATA_W-1:0] vel,
                               input logic [DATA_W-1:0] refv);
        @(negedge i_clk);
        if (!quiet_tail && $urandom_range(0, 99) < idle_pct) begin
            sample_if.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        sample_if.valid     <= 1'b1;
        sample_if.position  <= pos;
        sample_if.velocity  <= vel;
        sample_if.reference <= refv;
        do @(posedge i_clk); while (!sample_if.ready);
        sb.add_sample(pos, vel, refv);
    endtask

    // Stop offering and let every due word come back
    task automatic wait_drained;
        @(negedge i_clk);
        sample_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [DATA_W-1:0] scaled_value();
        return $signed($urandom()) >>> $urandom_range(0, 24);
    endfunction

    function automatic logic [DATA_W-1:0] corner_value();
        case ($urandom_range(0, 5))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return 32'h0000_8000;
            default: return 32'hFFFF_8000;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_gain();
        logic [DATA_W-1:0] g;
        case ($urandom_range(0, 7))
            0:       g = 32'h8000_0000;
            1:       g = 32'h7FFF_FFFF;
            2:       g = 32'h0000_0000;
            3:       g = 32'h0001_0000;
            4:       g = 32'hFFFF_0000;
            5, 6:    g = $urandom_range(0, 1 << 19) - (1 << 18);
            default: g = $urandom();
        endcase
        return g;
    endfunction

    // Sizeable reference with a measure under 0.05 of it; small velocity in POS_VEL
    task automatic send_stall_sample(input logic [MODE_W-1:0] m);
        logic [DATA_W-1:0] rabs, refv, meas;
        int unsigned       r, lim;
        r = $urandom_range(0, 63);
        if (r == 0)
            rabs = 32'h8000_0000;
        else if (r < 32)
            rabs = $urandom_range(1 << 17, 1 << 22);
        else
            rabs = $urandom_range(1 << 17, 32'h7FFF_FFFF);
        refv = $urandom_range(0, 1) ? -rabs : rabs;
        lim  = ({32'b0, rabs} * MOVE_FRAC - 1) >> 16;
        meas = $urandom_range(0, lim);
        if ($urandom_range(0, 1))
            meas = -meas;
        if (m == MODE_POS_VEL)
            send_sample(meas, $urandom_range(0, 131072) - 65536, refv);
        else
            send_sample($urandom(), meas, refv);
    endtask

    // Random configuration, then a mix of free, stall-shaped and corner words
    task automatic run_mixed_phase(input bit hold_midway);
        logic [MODE_W-1:0] m;
        logic [DATA_W-1:0] maxo;
        int unsigned       r, n, pick;
        r = $urandom_range(0, 19);
        if (r == 0)
            m = MODE_OFF;
        else if (r == 1)
            m = MODE_SPARE;
        else if (r < 11)
            m = MODE_VEL;
        else
            m = MODE_POS_VEL;
        case ($urandom_range(0, 3))
            0:       maxo = 32'h0000_0000;
            1:       maxo = 32'h7FFF_FFFF;
            2:       maxo = $urandom();
            default: maxo = $urandom_range(0, 1 << 22);
        endcase
        write_reg(REG_STATE_COUNT, DATA_W'(m));
        write_reg(REG_GAIN_K0, pick_gain());
        write_reg(REG_GAIN_K1, pick_gain());
        write_reg(REG_MAX_OUTPUT, maxo);
        case ($urandom_range(0, 3))
            0:       idle_pct = 0;
            1:       idle_pct = 8;
            2:       idle_pct = 25;
            default: idle_pct = 50;
        endcase
        n = $urandom_range(60, 110);
        for (int i = 0; i < n; i++) begin
            // sender holds off until the pipeline is empty
            if (hold_midway && i == n / 2)
                wait_drained;
            pick = $urandom_range(0, 99);
            if (pick < 45)
                send_sample(scaled_value(), scaled_value(), scaled_value());
            else if (pick < 80)
                send_stall_sample(sb.mode);
            else
                send_sample(corner_value(), corner_value(), corner_value());
        end
        wait_drained;
    endtask

    // Long stall run split by an invalid-mode stretch, carried on past the limit
    task automatic run_stall_phase;
        logic [MODE_W-1:0] loop_mode;
        logic [DATA_W-1:0] k0;
        int unsigned       first_run, second_run;
        loop_mode = $urandom_range(0, 1) ? MODE_VEL : MODE_POS_VEL;
        k0 = $urandom_range(32'h0001_0000, 32'h7FFF_FFFF);
        if ($urandom_range(0, 1))
            k0 = -k0;
        idle_pct = $urandom_range(0, 1) ? 0 : 15;
        write_reg(REG_STATE_COUNT, DATA_W'(loop_mode));
        write_reg(REG_GAIN_K0, k0);
        write_reg(REG_GAIN_K1, $urandom_range(0, 131072) - 65536);
        write_reg(REG_MAX_OUTPUT, $urandom_range(0, 29000));
        first_run = $urandom_range(150, 300);
        repeat (first_run) send_stall_sample(loop_mode);
        wait_drained;

        // count must hold across words in an invalid mode
        write_reg(REG_STATE_COUNT, DATA_W'($urandom_range(0, 1) ? MODE_OFF : MODE_SPARE));
        repeat ($urandom_range(3, 8)) send_sample($urandom(), $urandom(), $urandom());
        wait_drained;

        write_reg(REG_STATE_COUNT, DATA_W'(loop_mode));
        second_run = STALL_MAX - first_run + $urandom_range(20, 60);
        repeat (second_run) send_stall_sample(loop_mode);
        // one free word usually releases the guard
        send_sample(scaled_value(), scaled_value(), scaled_value());
        wait_drained;
    endtask

    initial begin
        sb         = new();
        quiet_tail = 1'b0;
        idle_pct   = 0;
        i_rst_n    = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        sample_if.valid     = 1'b0;
        sample_if.position  = '0;
        sample_if.velocity  = '0;
        sample_if.reference = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < 4; i++)
            check_reg(t_reg_idx'(i));
        idle_pct = 20;

        // Velocity loop at extreme gains: saturation both ways, reference threshold
        write_reg(REG_STATE_COUNT, DATA_W'(MODE_VEL));
        write_reg(REG_GAIN_K0, 32'h8000_0000);
        write_reg(REG_GAIN_K1, 32'h7FFF_FFFF);
        write_reg(REG_MAX_OUTPUT, 32'hFFFF_FFFF);
        send_sample(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_sample(32'h0000_0000, 32'h0000_0000, 32'h0000_8000);
        send_sample(32'h0000_0000, 32'h0000_0000, 32'h0000_7FFF);
        send_sample(32'h0000_0000, 32'h0000_0000, 32'hFFFF_8000);
        wait_drained;

        // Position plus velocity, zero limit, stalled-measure boundary
        write_reg(REG_STATE_COUNT, DATA_W'(MODE_POS_VEL));
        write_reg(REG_GAIN_K0, 32'h7FFF_FFFF);
        write_reg(REG_GAIN_K1, 32'h8000_0000);
        write_reg(REG_MAX_OUTPUT, 32'h0000_0000);
        send_sample(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_sample(32'h0001_0000, 32'hFFFF_0000, 32'h0003_0000);
        send_sample(32'h0000_0000, 32'h0000_0000, 32'h0014_0000);
        send_sample(32'h0001_0003, 32'h0000_0000, 32'h0014_0000);
        send_sample(32'h0001_0004, 32'h0000_0000, 32'h0014_0000);
        wait_drained;

        // Unity gain against a unit limit: near-saturation boundary
        write_reg(REG_STATE_COUNT, DATA_W'(MODE_VEL));
        write_reg(REG_GAIN_K0, 32'h0001_0000);
        write_reg(REG_GAIN_K1, 32'h0000_0000);
        write_reg(REG_MAX_OUTPUT, 32'h0001_0000);
        send_sample(32'h0000_0000, 32'h0000_0000, 32'h0000_F333);
        send_sample(32'h0000_0000, 32'h0000_0000, 32'h0000_F332);
        send_sample(32'h0000_0000, 32'h0000_0000, 32'hFFFF_0CCD);
        send_sample(32'h0000_0000, 32'h0001_0003, 32'h0014_0000);
        send_sample(32'h0000_0000, 32'h0001_0004, 32'h0014_0000);
        wait_drained;

        // Both invalid modes
        write_reg(REG_STATE_COUNT, DATA_W'(MODE_OFF));
        send_sample($urandom(), $urandom(), $urandom());
        wait_drained;
        write_reg(REG_STATE_COUNT, DATA_W'(MODE_SPARE));
        send_sample($urandom(), $urandom(), $urandom());
        wait_drained;

        // Random part
        run_mixed_phase(1'b0);
        run_stall_phase();
        run_mixed_phase(1'b1);
        run_mixed_phase(1'b0);
        run_stall_phase();
        run_mixed_phase(1'b0);
        run_mixed_phase(1'b0);
        quiet_tail = 1'b1;
        run_mixed_phase(1'b0);

        wait_drained;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS lqr_state_feedback_stall_guard_top");
        else
            $display("FAIL lqr_state_feedback_stall_guard_top");
        $finish;
    end

    // Watchdog
    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("FAIL lqr_state_feedback_stall_guard_top");
        $finish;
    end

endmodule

### filelist.f
rtl/core/lqrsg_pkg.sv
rtl/core/lqrsg_in_if.sv
rtl/core/lqrsg_out_if.sv
rtl/core/lqrsg_calc.sv
rtl/core/lqr_state_feedback_stall_guard_top.sv
test/lqr_state_feedback_stall_guard_top_tb.sv
